@@ design/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, beat payload types and controller/datapath
// command and status types for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;

  localparam int OPC_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int FLD_TIME_W = 16;
  localparam int FLD_PRIO_W = 8;

  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPC_W-1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]      opcode;
    logic [SLOT_W-1:0]     slot;
    logic [FLD_TIME_W-1:0] arrival;
    logic [FLD_TIME_W-1:0] burst;
    logic [FLD_PRIO_W-1:0] prio;
  } pps_req_t;

  typedef struct packed {
    logic                  ran_valid;
    logic [SLOT_W-1:0]     ran_slot;
    logic                  finished;
    logic [FLD_TIME_W-1:0] finish_time;
    logic [FLD_TIME_W-1:0] turnaround;
    logic [FLD_TIME_W-1:0] waiting;
    logic                  all_done;
    logic [FLD_TIME_W-1:0] time_now;
    logic                  time_saturated;
  } pps_rsp_t;

  typedef struct packed {
    logic take;
    logic do_clear;
    logic do_load;
    logic scan_start;
    logic scan_step;
    logic update;
    logic settle;
    logic post;
  } pps_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             scan_last;
    logic             out_free;
  } pps_sts_t;

endpackage

@@ design/pps_stream_if.sv @@
// ----------------------------------------------------------------------------
// pps_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface pps_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ design/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a table of process slots with a
// saturating time counter; one result beat per request beat.
//
//   channel  dir  payload    beat meaning
//   req      in   pps_req_t  clear, load slot or tick one time unit
//   rsp      out  pps_rsp_t  ran slot, completion times, status
//
// clear, load and unused opcodes act in the execute state, then post.
// a tick first scans the table, which reads one slot per cycle through
// the single read port of the slot table, and then updates.
// reset clears flags, time and handshake state; the table itself is not
// cleared and an entry is only used once its slot is loaded.
// the output register holds a result while rsp stalls; the next request
// is accepted and run meanwhile, and waits only to post its result.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
  parameter int SLOTS     = pps_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  pps_stream_if.sink   req,
  pps_stream_if.source rsp
);
  import pps_pkg::*;

  pps_cmd_t cmd;
  pps_sts_t sts;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pps_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule

@@ design/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: accepts a beat, runs clear, load or the
// slot scan and update of a tick, then hands the result to the output.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pps_pkg::pps_sts_t sts,
  output pps_pkg::pps_cmd_t cmd
);
  import pps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_POST = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_next   = ST_POST;
          end
          OP_LOAD: begin
            cmd.do_load = 1'b1;
            state_next  = ST_POST;
          end
          OP_TICK: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          default: begin
            state_next = ST_POST;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        cmd.settle = 1'b1;
        state_next = ST_POST;
      end
      ST_POST: begin
        if (sts.out_free) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && sts.scan_last) |=> (state == ST_LAST))
    else $error("scan did not end after last slot");

  a_post_needs_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && !sts.out_free) |=> (state == ST_POST))
    else $error("left post state while output was busy");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == ST_EXEC))
    else $error("accepted beat did not start execution");

endmodule

@@ design/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Scheduler datapath: slot table RAM, loaded and done flags, time counter,
// sequential best-slot search, completion arithmetic and output register.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int SLOTS     = pps_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pps_pkg::pps_cmd_t cmd,
  output pps_pkg::pps_sts_t sts,
  input  pps_pkg::pps_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output pps_pkg::pps_rsp_t rsp_data
);
  import pps_pkg::*;

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = 3 * TIME_BITS + PRIO_BITS;

  pps_req_t req_q;

  logic [SLOTS-1:0]     loaded;
  logic [SLOTS-1:0]     done;
  logic [TIME_BITS-1:0] cur_time;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_valid;

  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_bur;
  logic [TIME_BITS-1:0] best_rem;
  logic [PRIO_BITS-1:0] best_pr;

  logic                 r_ran;
  logic                 r_finished;
  logic [TIME_BITS-1:0] r_fin;
  logic [TIME_BITS-1:0] r_turn;
  logic [TIME_BITS-1:0] r_wait;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [TIME_BITS-1:0] ld_arr;
  logic [TIME_BITS-1:0] ld_bur;
  logic [PRIO_BITS-1:0] ld_pr;
  logic                 load_ok;
  logic [IDX_W-1:0]     load_idx;

  logic [TIME_BITS-1:0] rd_arr;
  logic [TIME_BITS-1:0] rd_bur;
  logic [TIME_BITS-1:0] rd_rem;
  logic [PRIO_BITS-1:0] rd_pr;
  logic                 cand;
  logic                 take_cand;

  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] rem_new;
  logic                 fin_now;
  logic                 all_done;

  assign ld_arr   = TIME_BITS'(req_q.arrival);
  assign ld_bur   = TIME_BITS'(req_q.burst);
  assign ld_pr    = PRIO_BITS'(req_q.prio);
  assign load_ok  = (int'(req_q.slot) < SLOTS);
  assign load_idx = IDX_W'(req_q.slot);

  assign {rd_arr, rd_bur, rd_rem, rd_pr} = ram_rdata;

  assign cand      = loaded[cmp_idx] && !done[cmp_idx] && (rd_arr <= cur_time);
  assign take_cand = cmp_valid && cand && (!best_found || (rd_pr < best_pr));

  assign time_inc = (&cur_time) ? cur_time : cur_time + 1'b1;
  assign rem_new  = (best_rem != '0) ? best_rem - 1'b1 : best_rem;
  assign fin_now  = best_found && (rem_new == '0);
  assign all_done = &(~loaded | done);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_idx;
    ram_wdata = {ld_arr, ld_bur, ld_bur, ld_pr};
    if (cmd.do_load) begin
      ram_we = load_ok;
    end else if (cmd.update) begin
      ram_we    = best_found;
      ram_waddr = best_idx;
      ram_wdata = {best_arr, best_bur, rem_new, best_pr};
    end
  end

  pps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= '0;
      done       <= '0;
      cur_time   <= '0;
      scan_idx   <= '0;
      cmp_valid  <= 1'b0;
      best_found <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_step;
      if (cmd.take || cmd.scan_start) begin
        best_found <= 1'b0;
      end else if (take_cand) begin
        best_found <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.do_clear) begin
        loaded   <= '0;
        done     <= '0;
        cur_time <= '0;
      end
      if (cmd.do_load && load_ok) begin
        loaded[load_idx] <= 1'b1;
        done[load_idx]   <= (ld_bur == '0);
      end
      if (cmd.update) begin
        cur_time <= time_inc;
        if (fin_now) begin
          done[best_idx] <= 1'b1;
        end
      end
      if (cmd.post) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q      <= req_data;
      r_ran      <= 1'b0;
      r_finished <= 1'b0;
      r_fin      <= '0;
      r_turn     <= '0;
      r_wait     <= '0;
    end
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx;
    end
    if (take_cand) begin
      best_idx <= cmp_idx;
      best_arr <= rd_arr;
      best_bur <= rd_bur;
      best_rem <= rd_rem;
      best_pr  <= rd_pr;
    end
    if (cmd.update) begin
      r_ran      <= best_found;
      r_finished <= fin_now;
      if (fin_now) begin
        r_fin  <= time_inc;
        r_turn <= (time_inc >= best_arr) ? time_inc - best_arr : '0;
      end
    end
    if (cmd.settle && r_finished) begin
      r_wait <= (r_turn >= best_bur) ? r_turn - best_bur : '0;
    end
    if (cmd.post) begin
      rsp_data.ran_valid      <= r_ran;
      rsp_data.ran_slot       <= r_ran ? SLOT_W'(best_idx) : '0;
      rsp_data.finished       <= r_finished;
      rsp_data.finish_time    <= FLD_TIME_W'(r_fin);
      rsp_data.turnaround     <= FLD_TIME_W'(r_turn);
      rsp_data.waiting        <= FLD_TIME_W'(r_wait);
      rsp_data.all_done       <= all_done;
      rsp_data.time_now       <= FLD_TIME_W'(cur_time);
      rsp_data.time_saturated <= &cur_time;
    end
  end

  assign sts.op        = req_q.opcode;
  assign sts.scan_last = (scan_idx == IDX_W'(SLOTS - 1));
  assign sts.out_free  = !rsp_valid || rsp_ready;

  a_best_is_loaded: assert property (@(posedge clk) disable iff (rst)
    best_found |-> loaded[best_idx])
    else $error("selected slot is not loaded");

  a_finish_sets_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.update && fin_now) |=> done[$past(best_idx)])
    else $error("finished slot not marked done");

  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    !cmd.do_clear |=> (cur_time >= $past(cur_time)))
    else $error("time went backwards without clear");

  a_rsp_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.post))
    else $error("result appeared without post");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority scheduler. A directed table
// walks reset state, clear, load, idle and preempting ticks, ties and reloads.
// Random job sets of loads and ticks follow, with noise items, and a short
// tail reloads a slot after a clear and runs it out. Every result beat is
// compared against the expected beat of its directed row or of a scheduler
// model kept in the bench, with random source bursts and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import pps_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [FLD_TIME_W-1:0] TIME_TOP = '1;
  localparam int RAND_ITEMS = 1700;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 60;
  localparam pps_rsp_t NO_RSP = '0;

  typedef struct packed {
    pps_req_t req;
    logic     typed;
    pps_rsp_t rsp;
  } dir_row_t;

  // rsp order: ran_valid, ran_slot, finished, finish_time, turnaround, waiting,
  // all_done, time_now, time_saturated
  localparam int DIR_N = 21;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{OP_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0}},
    '{'{OP_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd1, 1'b0}},
    '{'{OP_LOAD, 4'd3, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd1, 1'b0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd2, 1'b0}},
    '{'{OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd2, 1'b0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd3, 1'b0}},
    '{'{OP_LOAD, 4'd5, 16'd0, 16'd2, 8'd7}, 1'b0, NO_RSP},
    '{'{OP_LOAD, 4'd2, 16'd0, 16'd1, 8'd7}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_LOAD, 4'd0, 16'd4, 16'd3, 8'd1}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_LOAD, 4'd0, 16'd0, 16'd1, 8'd200}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b0, NO_RSP},
    '{'{OP_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0}},
    '{'{OP_LOAD, 4'd0, 16'd0, 16'd1, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b1, 4'd0, 1'b1, 16'd1, 16'd1, 16'd0, 1'b1, 16'd1, 1'b0}},
    '{'{OP_TICK, 4'd0, 16'd0, 16'd0, 8'd0}, 1'b1,
      '{1'b0, 4'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd2, 1'b0}}
  };

  logic clk;
  logic rst;

  pps_stream_if #(.payload_t(pps_req_t)) req_if ();
  pps_stream_if #(.payload_t(pps_rsp_t)) rsp_if ();

  preemptive_priority_scheduler_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // scheduler model state
  logic [FLD_TIME_W-1:0] tab_arrival [SLOTS_DEF];
  logic [FLD_TIME_W-1:0] tab_burst [SLOTS_DEF];
  logic [FLD_TIME_W-1:0] tab_left [SLOTS_DEF];
  logic [FLD_PRIO_W-1:0] tab_prio [SLOTS_DEF];
  logic                  slot_used [SLOTS_DEF];
  logic                  slot_done [SLOTS_DEF];
  logic [FLD_TIME_W-1:0] now_t;

  pps_rsp_t rsp_due [$];
  pps_rsp_t rsp_head;

  bit gap_on;
  int stall_mode;
  int hold_left;
  int burst_left;
  int cyc_cnt;
  int n_items;
  int n_ran;
  int n_fin;
  int n_sat;
  int mism_cnt;
  int extra_cnt;

  function automatic bit every_slot_done();
    for (int i = 0; i < SLOTS_DEF; i++)
      if (slot_used[i] && !slot_done[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic pps_rsp_t sched_step(pps_req_t r);
    pps_rsp_t o;
    int pick;
    logic [FLD_PRIO_W-1:0] best;
    logic [FLD_TIME_W-1:0] turn;
    o = '0;
    pick = -1;
    best = '0;
    case (r.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          tab_arrival[i] = '0;
          tab_burst[i] = '0;
          tab_left[i] = '0;
          tab_prio[i] = '0;
          slot_used[i] = 1'b0;
          slot_done[i] = 1'b0;
        end
        now_t = '0;
      end
      OP_LOAD: begin
        tab_arrival[r.slot] = r.arrival;
        tab_burst[r.slot] = r.burst;
        tab_left[r.slot] = r.burst;
        tab_prio[r.slot] = r.prio;
        slot_used[r.slot] = 1'b1;
        slot_done[r.slot] = (r.burst == '0);
      end
      OP_TICK: begin
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (slot_used[i] && !slot_done[i] && tab_arrival[i] <= now_t &&
              (pick < 0 || tab_prio[i] < best)) begin
            pick = i;
            best = tab_prio[i];
          end
        end
        if (now_t != TIME_TOP) now_t++;
        if (pick >= 0) begin
          o.ran_valid = 1'b1;
          o.ran_slot = 4'(pick);
          if (tab_left[pick] != '0) tab_left[pick]--;
          if (tab_left[pick] == '0) begin
            slot_done[pick] = 1'b1;
            o.finished = 1'b1;
            o.finish_time = now_t;
            turn = (now_t >= tab_arrival[pick]) ? now_t - tab_arrival[pick] : '0;
            o.turnaround = turn;
            o.waiting = (turn >= tab_burst[pick]) ? turn - tab_burst[pick] : '0;
          end
        end
      end
      default: ;
    endcase
    o.all_done = every_slot_done();
    o.time_now = now_t;
    o.time_saturated = (now_t == TIME_TOP);
    return o;
  endfunction

  function automatic pps_req_t mk_req(logic [OPC_W-1:0] op);
    pps_req_t r;
    r.opcode = op;
    r.slot = 4'($urandom_range(0, SLOTS_DEF - 1));
    r.arrival = 16'($urandom);
    r.burst = 16'($urandom);
    r.prio = 8'($urandom);
    return r;
  endfunction

  function automatic pps_req_t mk_load(int span);
    pps_req_t r;
    int k;
    r = mk_req(OP_LOAD);
    k = $urandom_range(0, 99);
    if (k >= 5) r.arrival = now_t + 16'($urandom_range(0, 24));
    k = $urandom_range(0, 99);
    if (k < 10) r.burst = '0;
    else if (k < 90) r.burst = 16'($urandom_range(1, 8));
    else if (k < 97) r.burst = 16'($urandom_range(9, 300));
    r.prio = 8'($urandom_range(0, span - 1));
    return r;
  endfunction

  task automatic put_req(input pps_req_t beat, input bit typed, input pps_rsp_t want);
    pps_rsp_t guess;
    req_if.valid <= 1'b1;
    req_if.data <= beat;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    guess = sched_step(beat);
    rsp_due.push_back(typed ? want : guess);
    n_items++;
    if (gap_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sink stall pattern
  always @(posedge clk) begin
    if (stall_mode == 0) begin
      rsp_if.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      rsp_if.ready <= !rsp_if.ready;
      hold_left <= rsp_if.ready ? $urandom_range(0, stall_mode == 2 ? 40 : 6)
                                : $urandom_range(0, 10);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (rsp_due.size() == 0) begin
        extra_cnt++;
        if (mism_cnt + extra_cnt <= 10)
          $display("result beat with nothing pending: %p", rsp_if.data);
      end else begin
        rsp_head = rsp_due.pop_front();
        if (rsp_if.data !== rsp_head) begin
          mism_cnt++;
          if (mism_cnt + extra_cnt <= 10)
            $display("mismatch: expected %p got %p", rsp_head, rsp_if.data);
        end else begin
          if (rsp_head.ran_valid) n_ran++;
          if (rsp_head.finished) n_fin++;
          if (rsp_head.time_saturated) n_sat++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cyc_cnt, rsp_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pps_req_t r;
    int span;
    int nticks;
    int n_rand;
    int k;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    gap_on = 1'b1;
    stall_mode = 1;
    hold_left = 0;
    burst_left = 0;
    cyc_cnt = 0;
    n_items = 0;
    n_ran = 0;
    n_fin = 0;
    n_sat = 0;
    mism_cnt = 0;
    extra_cnt = 0;
    n_rand = 0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      slot_used[i] = 1'b0;
      slot_done[i] = 1'b0;
    end
    now_t = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      put_req(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].rsp);

    // random job sets: loads then ticks until everything completes or 150 ticks have run
    while (n_rand < RAND_ITEMS) begin
      gap_on = ($urandom_range(0, 3) != 0);
      stall_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: span = 1;
        1: span = 4;
        2: span = 16;
        default: span = 256;
      endcase
      if ($urandom_range(0, 4) != 0) begin
        put_req(mk_req(OP_CLEAR), 1'b0, NO_RSP);
        n_rand++;
      end
      repeat ($urandom_range(1, SLOTS_DEF)) begin
        put_req(mk_load(span), 1'b0, NO_RSP);
        n_rand++;
      end
      nticks = 0;
      while (!every_slot_done() && nticks < 150) begin
        k = $urandom_range(0, 99);
        if (k < 7) begin
          put_req(mk_load(span), 1'b0, NO_RSP);
          n_rand++;
        end else if (k < 10) begin
          put_req(mk_req(OP_UNUSED), 1'b0, NO_RSP);
        end else if (k < 11) begin
          put_req(mk_req(OP_CLEAR), 1'b0, NO_RSP);
          n_rand++;
        end else begin
          put_req(mk_req(OP_TICK), 1'b0, NO_RSP);
          nticks++;
          n_rand++;
        end
      end
      repeat ($urandom_range(0, 2)) begin
        put_req(mk_req(OP_TICK), 1'b0, NO_RSP);
        n_rand++;
      end
    end

    // short tail: reload after a clear and run the slot out
    gap_on = 1'b0;
    stall_mode = 0;
    put_req(mk_req(OP_CLEAR), 1'b0, NO_RSP);
    r = mk_req(OP_LOAD);
    r.slot = 4'd7;
    r.arrival = '0;
    r.burst = 16'd2;
    r.prio = 8'd0;
    put_req(r, 1'b0, NO_RSP);
    repeat (3) put_req(mk_req(OP_TICK), 1'b0, NO_RSP);
    put_req(mk_req(OP_CLEAR), 1'b0, NO_RSP);
    put_req(mk_req(OP_TICK), 1'b0, NO_RSP);

    req_if.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d request beats (%0d from the directed table); %0d ticks ran a slot,",
             n_items, DIR_N, n_ran);
    $display("%0d slots completed, %0d results at saturated time; %0d mismatches, %0d extra",
             n_fin, n_sat, mism_cnt, extra_cnt);
    if (mism_cnt == 0 && extra_cnt == 0 && rsp_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
